// ----- src/odd_part_partition_generator_unit_macros.svh -----
// Assertion helpers for the odd-part partition generator.
// The checks are compiled out for synthesis.
`ifndef ODD_PART_PARTITION_GENERATOR_UNIT_MACROS_SVH
`define ODD_PART_PARTITION_GENERATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on the rising clock edge, masked while reset is active.
`define OPG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that an antecedent implies a consequent in the next cycle.
`define OPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define OPG_ASSERT(lbl, clk, rst_n, prop)
`define OPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/opg_pkg.sv -----
`default_nettype none
package opg_pkg;

    // Sizes
    localparam int MAX_N  = 32;
    localparam int PART_W = 6;
    localparam int IDX_W  = $clog2(MAX_N);
    localparam int REM_W  = 6;

    // Largest value a start may load: MAX_N, capped to what a part holds
    localparam int LIM_N = (MAX_N < 63) ? MAX_N : 63;

    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(MAX_N - 1);
    localparam logic [PART_W-1:0] START_LIM = PART_W'(LIM_N);

    // Input kind codes
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_NEXT  = 1'b1;

    // Controller states
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_STRIP = 5'b00010,
        S_FILL  = 5'b00100,
        S_EMIT  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;      // input transaction taken
        logic load_start;  // load a nonzero start value
        logic start_zero;  // start with zero: nothing loaded
        logic adv_init;    // begin stepping from the current partition
        logic strip;       // one strip step at k
        logic fill;        // one refill step after k
        logic exhaust;     // sequence ran out
        logic emit_part;   // load output with part i
        logic emit_done;   // load output with the done result
        logic rd_emit;     // part store read address is i, not k
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic exhausted;
        logic pk_one;      // part at k is one
        logic k_zero;      // k at the first part
        logic fill_more;   // remainder still above the refill part
        logic top_even;    // new last index is even (odd part count)
        logic emit_last;   // i is the last part
        logic out_free;    // output register can take a result
    } t_sts;

endpackage
`default_nettype wire

// ----- src/opg_ctrl.sv -----
`default_nettype none
module opg_ctrl
    import opg_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_kind,
    input  wire logic i_value_zero,
    input  wire t_sts i_sts,
    output logic      o_in_ready,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_kind == KIND_START) begin
                        if (i_value_zero) begin
                            o_cmd.start_zero = 1'b1;
                            n_state          = S_DONE;
                        end else begin
                            o_cmd.load_start = 1'b1;
                            n_state          = S_EMIT;
                        end
                    end else if (i_sts.exhausted) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.adv_init = 1'b1;
                        n_state        = S_STRIP;
                    end
                end
            end
            S_STRIP: begin
                // all parts are ones: no next partition
                if (i_sts.pk_one && i_sts.k_zero) begin
                    o_cmd.exhaust = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.strip = 1'b1;
                    if (!i_sts.pk_one) begin
                        n_state = S_FILL;
                    end
                end
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (!i_sts.fill_more) begin
                    // even-length partitions are skipped
                    n_state = i_sts.top_even ? S_EMIT : S_STRIP;
                end
            end
            S_EMIT: begin
                o_cmd.rd_emit = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.emit_part = 1'b1;
                    if (i_sts.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_done = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- src/opg_dp.sv -----
`default_nettype none
module opg_dp
    import opg_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    input  wire logic [PART_W-1:0] i_value,
    input  wire logic              i_out_ready,
    output t_sts                   o_sts,
    output logic                   o_out_valid,
    output logic [PART_W-1:0]      o_part,
    output logic [IDX_W-1:0]       o_part_index,
    output logic                   o_last,
    output logic                   o_done
);

    // Partition store, one write and one read address per cycle
    logic [PART_W-1:0] r_parts [MAX_N];

    logic [IDX_W-1:0]  r_k, n_k;
    logic [IDX_W-1:0]  r_i, n_i;
    logic [IDX_W-1:0]  r_top, n_top;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [PART_W-1:0] r_p, n_p;
    logic              r_exh, n_exh;
    logic              r_ov, n_ov;

    logic [PART_W-1:0] r_opart;
    logic [IDX_W-1:0]  r_oidx;
    logic              r_olast;
    logic              r_odone;

    logic [IDX_W-1:0]  rd_addr;
    logic [PART_W-1:0] rd_data;
    logic              k_last;
    logic [IDX_W-1:0]  new_top;
    logic [PART_W-1:0] start_val;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [PART_W-1:0] wdata;

    // Store read
    assign rd_addr = i_cmd.rd_emit ? r_i : r_k;
    assign rd_data = r_parts[rd_addr];

    assign k_last    = (r_k == LAST_IDX);
    assign new_top   = k_last ? r_k : (r_k + 1'b1);
    assign start_val = (i_value > START_LIM) ? START_LIM : i_value;

    // Status
    assign o_sts.exhausted = r_exh;
    assign o_sts.pk_one    = (rd_data == PART_W'(1));
    assign o_sts.k_zero    = (r_k == '0);
    assign o_sts.fill_more = (r_rem > REM_W'(r_p)) && !k_last;
    assign o_sts.top_even  = ~new_top[0];
    assign o_sts.emit_last = (r_i == r_top);
    assign o_sts.out_free  = !r_ov || i_out_ready;

    // Store write select
    always_comb begin
        we    = 1'b0;
        waddr = r_k;
        wdata = rd_data - 1'b1;
        if (i_cmd.load_start) begin
            we    = 1'b1;
            waddr = '0;
            wdata = start_val;
        end else if (i_cmd.strip && !o_sts.pk_one) begin
            we = 1'b1;
        end else if (i_cmd.fill && !k_last) begin
            we    = 1'b1;
            waddr = r_k + 1'b1;
            wdata = o_sts.fill_more ? r_p : PART_W'(r_rem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_parts[waddr] <= wdata;
        end
    end

    // Stepping and output control
    always_comb begin
        n_k   = r_k;
        n_i   = r_i;
        n_top = r_top;
        n_rem = r_rem;
        n_p   = r_p;
        n_exh = r_exh;
        n_ov  = r_ov;
        if (i_cmd.accept) begin
            n_i = '0;
        end
        if (i_cmd.load_start) begin
            n_top = '0;
            n_exh = 1'b0;
        end
        if (i_cmd.start_zero || i_cmd.exhaust) begin
            n_top = '0;
            n_exh = 1'b1;
        end
        if (i_cmd.adv_init) begin
            n_k   = r_top;
            n_rem = '0;
        end
        if (i_cmd.strip) begin
            n_rem = r_rem + 1'b1;
            if (o_sts.pk_one) begin
                n_k = r_k - 1'b1;
            end else begin
                n_p = rd_data - 1'b1;
            end
        end
        if (i_cmd.fill) begin
            if (o_sts.fill_more) begin
                n_rem = r_rem - REM_W'(r_p);
                n_k   = r_k + 1'b1;
            end else begin
                n_top = new_top;
                n_k   = new_top;
                n_rem = '0;
                n_i   = '0;
            end
        end
        if (i_cmd.emit_part) begin
            n_i = r_i + 1'b1;
        end
        if (i_cmd.emit_part || i_cmd.emit_done) begin
            n_ov = 1'b1;
        end else if (i_out_ready) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k   <= '0;
            r_i   <= '0;
            r_top <= '0;
            r_rem <= '0;
            r_p   <= '0;
            r_exh <= 1'b1;
            r_ov  <= 1'b0;
        end else begin
            r_k   <= n_k;
            r_i   <= n_i;
            r_top <= n_top;
            r_rem <= n_rem;
            r_p   <= n_p;
            r_exh <= n_exh;
            r_ov  <= n_ov;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_part) begin
            r_opart <= rd_data;
            r_oidx  <= r_i;
            r_olast <= o_sts.emit_last;
            r_odone <= 1'b0;
        end else if (i_cmd.emit_done) begin
            r_opart <= '0;
            r_oidx  <= '0;
            r_olast <= 1'b1;
            r_odone <= 1'b1;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_part       = r_opart;
    assign o_part_index = r_oidx;
    assign o_last       = r_olast;
    assign o_done       = r_odone;

endmodule
`default_nettype wire

// ----- src/odd_part_partition_generator_unit.sv -----
// Odd-length integer partition generator.
// Input stream: tuser[0] is the kind (start or next), tdata[5:0] the value n.
// A start loads n (saturated to 32) and returns the one-part partition n;
// a start with zero returns the done result. A next item steps through the
// partitions in reverse lexicographic order, skipping those with an even
// part count, and returns the next one as a run of parts, largest first,
// tlast on the final part. With nothing left it returns one done result.
// One input transaction is taken at a time; tready is high only when idle.
// Sequencing: after a start, or a next item with nothing loaded, the first
// result is loaded into the output register from the emit or done state.
// After a next item the sequencer strips each trailing one, lowers the last
// part above one, and runs the refill steps (each copy, then one closing
// step for the leftover), repeated over every skipped partition; the first
// part is loaded into the output register after the last step. Running out
// strips the trailing ones down to the first part, then the done result follows.
// Parts leave at one per cycle while the receiver takes them.
// Reset empties the generator: a next item before any start returns done.
// A stall on the output holds the current result in the output register
// and the sequencer waits; no result is lost or repeated.
`default_nettype none
`include "odd_part_partition_generator_unit_macros.svh"
module odd_part_partition_generator_unit
    import opg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [5:0] value
    input  wire logic [0:0]  s_axis_tuser,   // [0] kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [5:0] part, [10:6] part_index
    output logic             m_axis_tlast,
    output logic [0:0]       m_axis_tuser    // [0] done_res
);

    t_cmd              cmd;
    t_sts              sts;
    logic [PART_W-1:0] value;
    logic [PART_W-1:0] part;
    logic [IDX_W-1:0]  part_index;
    logic              done;

    assign value = s_axis_tdata[PART_W-1:0];

    opg_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_kind       (s_axis_tuser[0]),
        .i_value_zero (value == '0),
        .i_sts        (sts),
        .o_in_ready   (s_axis_tready),
        .o_cmd        (cmd)
    );

    opg_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_value      (value),
        .i_out_ready  (m_axis_tready),
        .o_sts        (sts),
        .o_out_valid  (m_axis_tvalid),
        .o_part       (part),
        .o_part_index (part_index),
        .o_last       (m_axis_tlast),
        .o_done       (done)
    );

    assign m_axis_tdata = {5'b0, part_index, part};
    assign m_axis_tuser = done;

    // Done result carries tlast and zero payload
    `OPG_ASSERT(a_done_shape, i_clk, i_rst_n,
        !(m_axis_tvalid && m_axis_tuser[0]) || (m_axis_tlast && (m_axis_tdata == 16'd0)))
    // A part of a partition is never zero
    `OPG_ASSERT(a_part_nonzero, i_clk, i_rst_n,
        !(m_axis_tvalid && !m_axis_tuser[0]) || (m_axis_tdata[5:0] != 6'd0))
    // No stepping while an input transaction can be taken
    `OPG_ASSERT(a_idle_no_step, i_clk, i_rst_n,
        !s_axis_tready || !(cmd.strip || cmd.fill || cmd.emit_part))
    // A nonzero start leaves a partition loaded
    `OPG_ASSERT_NEXT(a_start_loads, i_clk, i_rst_n, cmd.load_start, !sts.exhausted)

endmodule
`default_nettype wire

// ----- dv/opg_result_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module opg_result_checker
    import opg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [7:0]  i_in_data,    // [5:0] value
    input  wire logic [0:0]  i_in_user,    // [0] kind
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [15:0] i_out_data,   // [5:0] part, [10:6] part_index
    input  wire logic        i_out_last,
    input  wire logic [0:0]  i_out_user,   // [0] done_res
    output int               o_mismatches,
    output int               o_pending
);

    typedef struct {
        logic [PART_W-1:0] part;
        logic [IDX_W-1:0]  index;
        logic              last;
        logic              done;
    } t_part_txn;

    // Expected part transactions, oldest first
    t_part_txn         expected_parts[$];

    // Shadow of the generator state
    logic [PART_W-1:0] cur_parts [MAX_N];
    int                top_pos;
    bit                gen_exhausted;
    int                mismatches;

    function automatic void queue_done();
        t_part_txn t;
        t.part  = '0;
        t.index = '0;
        t.last  = 1'b1;
        t.done  = 1'b1;
        expected_parts.push_back(t);
    endfunction

    function automatic void queue_partition();
        t_part_txn t;
        for (int i = 0; i <= top_pos && i < MAX_N; i++) begin
            t.part  = cur_parts[i];
            t.index = IDX_W'(i);
            t.last  = (i == top_pos);
            t.done  = 1'b0;
            expected_parts.push_back(t);
        end
    endfunction

    // Next partition in reverse lex order; 0 when none is left
    function automatic bit step_partition();
        int k;
        int rem;
        k   = top_pos;
        rem = 0;
        // strip trailing ones
        while (k >= 0 && cur_parts[k] == 1) begin
            rem++;
            k--;
        end
        if (k < 0) return 1'b0;
        cur_parts[k] = cur_parts[k] - 1'b1;
        rem++;
        // refill with copies of the lowered part, then the leftover
        while (rem > int'(cur_parts[k]) && k + 1 < MAX_N) begin
            cur_parts[k+1] = cur_parts[k];
            rem -= int'(cur_parts[k]);
            k++;
        end
        if (k + 1 < MAX_N) begin
            cur_parts[k+1] = PART_W'(rem);
            k++;
        end
        top_pos = k;
        return 1'b1;
    endfunction

    function automatic void predict_item(input logic kind, input logic [PART_W-1:0] value);
        logic [PART_W-1:0] n;
        n = value;
        if (kind == KIND_START) begin
            top_pos = 0;
            if (n == 0) begin
                gen_exhausted = 1'b1;
                queue_done();
            end else begin
                if (n > START_LIM) n = START_LIM;
                cur_parts[0]  = n;
                gen_exhausted = 1'b0;
                queue_partition();
            end
        end else if (gen_exhausted) begin
            queue_done();
        end else begin
            // skip partitions with an even part count
            forever begin
                if (!step_partition()) begin
                    gen_exhausted = 1'b1;
                    top_pos = 0;
                    queue_done();
                    return;
                end
                if ((top_pos % 2) == 0) begin
                    queue_partition();
                    return;
                end
            end
        end
    endfunction

    task automatic check_result();
        t_part_txn got;
        t_part_txn want;
        got.part  = i_out_data[PART_W-1:0];
        got.index = i_out_data[PART_W +: IDX_W];
        got.last  = i_out_last;
        got.done  = i_out_user[0];
        if (expected_parts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result with none expected: %s %0d index %0d last %0b done %0b",
                         $realtime, "part", got.part, got.index, got.last, got.done);
        end else begin
            want = expected_parts.pop_front();
            if (got.part !== want.part || got.index !== want.index ||
                got.last !== want.last || got.done !== want.done) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: mismatch exp part %0d index %0d last %0b done %0b,",
                              " got part %0d index %0d last %0b done %0b"},
                             $realtime, want.part, want.index, want.last, want.done,
                             got.part, got.index, got.last, got.done);
            end
        end
    endtask

    // Predict on input transactions, compare on output transactions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_parts.delete();
            foreach (cur_parts[i]) cur_parts[i] = '0;
            top_pos       = 0;
            gen_exhausted = 1'b1;
        end else begin
            if (i_in_valid && i_in_ready) predict_item(i_in_user[0], i_in_data[PART_W-1:0]);
            if (i_out_valid && i_out_ready) check_result();
        end
        o_mismatches <= mismatches;
        o_pending    <= expected_parts.size();
    end

    initial begin
        mismatches   = 0;
        o_mismatches = 0;
        o_pending    = 0;
    end

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import opg_pkg::*;

    localparam int ITEM_TARGET = 400;
    localparam int CYCLE_LIMIT = 2_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [5:0] value
    logic [0:0]  s_axis_tuser;    // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;    // [5:0] part, [10:6] part_index
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;    // [0] done_res

    int mismatches;
    int pending;
    int items_sent;
    int cycle_count;
    bit sender_quiet;
    bit recv_quiet;

    odd_part_partition_generator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    opg_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_last   (m_axis_tlast),
        .i_out_user   (m_axis_tuser),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // Receiver: random stall before each result
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = recv_quiet ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // One input transaction after a random gap
    task automatic offer_item(input logic kind, input logic [5:0] value);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 15);
        @(negedge i_clk);
        if (gap != 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = {2'b00, value};
        s_axis_tuser  = kind;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Hold off the sender until every expected part is back
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic run_sequence(input logic [5:0] n, input int steps);
        offer_item(KIND_START, n);
        repeat (steps) offer_item(KIND_NEXT, 6'($urandom_range(0, 63)));
    endtask

    initial begin
        int sel;
        logic [5:0] n;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        items_sent    = 0;
        sender_quiet  = 1'b0;
        recv_quiet    = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty generator, zero start, saturation, full small runs
        offer_item(KIND_NEXT, 6'd0);
        offer_item(KIND_START, 6'd0);
        offer_item(KIND_NEXT, 6'd63);
        run_sequence(6'd1, 2);
        run_sequence(6'd63, 3);
        run_sequence(6'd32, 1);
        run_sequence(6'd33, 0);
        run_sequence(6'd5, 4);
        run_sequence(6'd2, 1);
        run_sequence(6'd3, 3);
        run_sequence(6'd21, 0);
        wait_drained();

        // One long run to exhaustion, reaching partitions with many parts
        offer_item(KIND_START, 6'd17);
        for (int i = 0; i < 155; i++) begin
            if (i % 25 == 0) begin
                sender_quiet = ($urandom_range(0, 3) == 0);
                recv_quiet   = ($urandom_range(0, 3) == 0);
            end
            offer_item(KIND_NEXT, 6'($urandom_range(0, 63)));
        end

        // Random sequences with some noise
        while (items_sent < ITEM_TARGET) begin
            sender_quiet = ($urandom_range(0, 3) == 0);
            recv_quiet   = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 99);
            if (sel < 12) begin
                repeat ($urandom_range(1, 4))
                    offer_item(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
            end else begin
                sel = $urandom_range(0, 9);
                if (sel < 6)       n = 6'($urandom_range(1, 12));
                else if (sel < 8)  n = 6'($urandom_range(13, 32));
                else if (sel == 8) n = 6'($urandom_range(33, 63));
                else               n = 6'd0;
                run_sequence(n, $urandom_range(0, 30));
            end
            if ($urandom_range(0, 7) == 0) wait_drained();
        end

        // Drain and let the block settle
        wait_drained();
        repeat (32) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+src
src/opg_pkg.sv
src/opg_ctrl.sv
src/opg_dp.sv
src/odd_part_partition_generator_unit.sv
dv/opg_result_checker.sv
dv/tb.sv
